// ===== src/sti_pkg.sv =====
// sti_pkg: shared widths, codes and the operand bundle of the sorted table interpolator.
// No dependencies; imported by sti_muldiv and sorted_table_interpolator_core.
`timescale 1ns / 1ps

package sti_pkg;

  localparam int DATA_W      = 32;  // Q16.16 words
  localparam int ENTRY_W     = 10;  // entry_index / segment_upper port width
  localparam int CNT_W       = 11;  // sample_count register width
  localparam int MAG_W       = 33;  // magnitude of a difference of two Q16.16 words
  localparam int QUOT_W      = 34;  // offset quotient before the cap
  localparam int MIN_SAMPLES = 2;

  localparam logic [QUOT_W-1:0] OFFSET_CAP = 34'h2_0000_0000;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  // |dq|, |dy| and |dx| handed to the multiply/divide unit
  typedef struct packed {
    logic [MAG_W-1:0] mul_a;
    logic [MAG_W-1:0] mul_b;
    logic [MAG_W-1:0] div_d;
  } md_operands_t;

endpackage

// ===== src/sti_ram.sv =====
// sti_ram: generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/sti_muldiv.sv =====
// sti_muldiv: |dq| * |dy| / |dx| over one shared 34-bit adder, shift-add then restoring divide.
// Depends on sti_pkg. Result is capped at OFFSET_CAP.
`timescale 1ns / 1ps

module sti_muldiv
  import sti_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  md_operands_t       ops,
  output logic               done,
  output logic [QUOT_W-1:0]  offset
);

  localparam int STEP_W = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_CHK,
    M_DIV,
    M_DONE
  } phase_t;

  phase_t           phase;
  logic [STEP_W-1:0] step;
  md_operands_t     opr;
  logic [MAG_W-1:0] acc;   // product high part, then remainder
  logic [QUOT_W-1:0] low;  // multiplier / product low part, then dividend bits and quotient
  logic             ovf;

  logic [QUOT_W-1:0] add_a;
  logic [QUOT_W-1:0] add_b;
  logic              add_sub;
  logic [QUOT_W:0]   add_sum;
  logic              carry;

  // the one adder; on subtract, carry set means add_a >= add_b
  assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                 + {{QUOT_W{1'b0}}, add_sub};
  assign carry   = add_sum[QUOT_W];

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (phase)
      M_MUL: begin
        add_a = {1'b0, acc};
        add_b = low[0] ? {1'b0, opr.mul_b} : '0;
      end
      M_CHK: begin
        // quotient >= 2^34 when product >> 34 is not below the divisor
        add_a   = {2'b00, acc[MAG_W-1:1]};
        add_b   = {1'b0, opr.div_d};
        add_sub = 1'b1;
      end
      M_DIV: begin
        add_a   = {acc, low[QUOT_W-1]};
        add_b   = {1'b0, opr.div_d};
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
    end else begin
      unique case (phase)
        M_IDLE: begin
          if (start) begin
            opr   <= ops;
            acc   <= '0;
            low   <= {1'b0, ops.mul_a};
            ovf   <= 1'b0;
            step  <= '0;
            phase <= M_MUL;
          end
        end
        M_MUL: begin
          acc  <= add_sum[MAG_W:1];
          low  <= {1'b0, add_sum[0], low[MAG_W-1:1]};
          step <= step + 1'b1;
          if (step == STEP_W'(MAG_W - 1)) begin
            phase <= M_CHK;
          end
        end
        M_CHK: begin
          if (carry) begin
            ovf   <= 1'b1;
            phase <= M_DONE;
          end else begin
            acc   <= {1'b0, acc[MAG_W-1:1]};
            low   <= {acc[0], low[MAG_W-1:0]};
            step  <= '0;
            phase <= M_DIV;
          end
        end
        M_DIV: begin
          acc  <= carry ? add_sum[MAG_W-1:0] : add_a[MAG_W-1:0];
          low  <= {low[QUOT_W-2:0], carry};
          step <= step + 1'b1;
          if (step == STEP_W'(QUOT_W - 1)) begin
            phase <= M_DONE;
          end
        end
        M_DONE: begin
          phase <= M_IDLE;
        end
        default: begin
          phase <= M_IDLE;
        end
      endcase
    end
  end

  assign done   = (phase == M_DONE);
  assign offset = (ovf || (low[QUOT_W-1] && (|low[QUOT_W-2:0]))) ? OFFSET_CAP : low;

endmodule

// ===== src/sorted_table_interpolator_core.sv =====
// sorted_table_interpolator_core: piecewise-linear lookup over a sorted Q16.16 sample table.
// Depends on sti_pkg, sti_ram (x and y tables) and sti_muldiv (shared mul/div unit).
`timescale 1ns / 1ps

// Usage
//  - Input channel (in_valid / in_stall): one transfer carries req_type plus all payload fields.
//    A write (REQ_WRITE) stores entry_x / entry_y at entry_index on the accepting edge and produces no
//    result; indexes at or above MAX_ENTRIES are dropped. A query (REQ_QUERY) looks up query_x.
//  - Output channel (out_valid / out_stall): one transfer per query with hit, segment_upper,
//    echo_x and interp_y. A miss returns hit = 0 with zero index and y.
//  - Config channel (cfg_valid / cfg_ready): writes sample_count; ready only while idle.
//  - Query time is set by the upper-bound search (probes of the registered-read table,
//    one read at a time) and the shared mul/div unit (33 multiply steps, one range check,
//    34 divide steps). Misses found by the range check skip both. The block works on one
//    query at a time and holds in_stall high until it returns to idle.
//  - A finished result sits in the output register; the next item is accepted while it waits.
//    If a second query completes while the output is still stalled it waits until the
//    register frees up.
//  - Reset (rst, synchronous) clears sample_count, the sequencer and out_valid. Table
//    contents are not cleared; read only entries that have been written.

module sorted_table_interpolator_core
  import sti_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  // item input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [ENTRY_W-1:0]       entry_index,
  input  logic signed [DATA_W-1:0] entry_x,
  input  logic signed [DATA_W-1:0] entry_y,
  input  logic signed [DATA_W-1:0] query_x,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic [ENTRY_W-1:0]       segment_upper,
  output logic signed [DATA_W-1:0] echo_x,
  output logic signed [DATA_W-1:0] interp_y,
  // sample_count write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_FIRST,
    S_GOT_FIRST,
    S_RD_LAST,
    S_GOT_LAST,
    S_SRCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD_LO,
    S_GOT_LO,
    S_RD_HI,
    S_GOT_HI,
    S_MAG,
    S_MULDIV,
    S_SUM,
    S_DONE
  } state_t;

  state_t state;

  logic [CNT_W-1:0]         sample_count;
  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] first_x;
  logic [AW-1:0]            lo;       // search base; holds the upper segment index at the end
  logic [AW-1:0]            len;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] x1;
  logic signed [DATA_W-1:0] y1;
  logic signed [MAG_W-1:0]  dx;
  logic signed [MAG_W-1:0]  dy;
  logic signed [MAG_W-1:0]  dq;
  logic                     neg;
  logic signed [DATA_W+2:0] sum;      // y1 +/- offset, before saturation
  logic                     res_hit;
  logic signed [DATA_W-1:0] res_y;

  // table ports
  logic                     tbl_wr;
  logic [AW-1:0]            tbl_wr_addr;
  logic [DATA_W-1:0]        ram_x_q;
  logic [DATA_W-1:0]        ram_y_q;
  logic signed [DATA_W-1:0] rd_xs;
  logic signed [DATA_W-1:0] rd_ys;

  // count in use and last index
  logic [31:0]              n_full;
  logic [31:0]              n_m1;
  logic                     n_ok;
  logic [AW-1:0]            n_last;

  // mul/div unit
  logic                     md_start;
  md_operands_t             md_ops;
  logic                     md_done;
  logic [QUOT_W-1:0]        md_offset;

  logic in_xfer;
  logic [AW-1:0] half;

  function automatic logic [MAG_W-1:0] mag33(input logic signed [MAG_W-1:0] v);
    mag33 = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  // a count above the table size acts as the table size
  assign n_full = (32'(sample_count) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
                                                         : 32'(sample_count);
  assign n_m1   = n_full - 32'd1;
  assign n_ok   = (n_full >= 32'(MIN_SAMPLES));
  assign n_last = n_m1[AW-1:0];

  assign half = len >> 1;

  // writes go straight to the tables on the accepting edge
  assign tbl_wr      = in_xfer && (req_type == REQ_WRITE)
                       && (32'(entry_index) < 32'(MAX_ENTRIES));
  assign tbl_wr_addr = AW'(entry_index);

  assign rd_xs = $signed(ram_x_q);
  assign rd_ys = $signed(ram_y_q);

  sti_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_x_ram (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_wr_addr),
    .wr_data (entry_x),
    .rd_addr (rd_addr),
    .rd_data (ram_x_q)
  );

  sti_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_y_ram (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_wr_addr),
    .wr_data (entry_y),
    .rd_addr (rd_addr),
    .rd_data (ram_y_q)
  );

  assign md_start     = (state == S_MAG) && (dx != '0);
  assign md_ops.mul_a = mag33(dq);
  assign md_ops.mul_b = mag33(dy);
  assign md_ops.div_d = mag33(dx);

  sti_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .ops    (md_ops),
    .done   (md_done),
    .offset (md_offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_count <= cfg_data;
      end
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer && (req_type == REQ_QUERY)) begin
            q <= query_x;
            if (n_ok) begin
              rd_addr <= '0;
              state   <= S_RD_FIRST;
            end else begin
              res_hit <= 1'b0;
              state   <= S_DONE;
            end
          end
        end
        S_RD_FIRST: begin
          state <= S_GOT_FIRST;
        end
        S_GOT_FIRST: begin
          first_x <= rd_xs;
          rd_addr <= n_last;
          state   <= S_RD_LAST;
        end
        S_RD_LAST: begin
          state <= S_GOT_LAST;
        end
        S_GOT_LAST: begin
          // range check: last above first, query inside [first, last]
          if (!((rd_xs > first_x) && (q >= first_x) && (q <= rd_xs))) begin
            res_hit <= 1'b0;
            state   <= S_DONE;
          end else if (q == rd_xs) begin
            lo    <= n_last;
            len   <= '0;
            state <= S_SRCH;
          end else begin
            lo    <= '0;
            len   <= n_last;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (len == '0) begin
            if (lo == '0) begin
              // search ran off the front: only on an unsorted table
              res_hit <= 1'b0;
              state   <= S_DONE;
            end else begin
              rd_addr <= lo - 1'b1;
              state   <= S_RD_LO;
            end
          end else begin
            rd_addr <= lo + half;
            state   <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (q < rd_xs) begin
            len <= half;
          end else begin
            lo  <= rd_addr + 1'b1;
            len <= len - half - 1'b1;
          end
          state <= S_SRCH;
        end
        S_RD_LO: begin
          state <= S_GOT_LO;
        end
        S_GOT_LO: begin
          x1      <= rd_xs;
          y1      <= rd_ys;
          rd_addr <= lo;
          state   <= S_RD_HI;
        end
        S_RD_HI: begin
          state <= S_GOT_HI;
        end
        S_GOT_HI: begin
          dx    <= {rd_xs[DATA_W-1], rd_xs} - {x1[DATA_W-1], x1};
          dy    <= {rd_ys[DATA_W-1], rd_ys} - {y1[DATA_W-1], y1};
          dq    <= {q[DATA_W-1], q} - {x1[DATA_W-1], x1};
          state <= S_MAG;
        end
        S_MAG: begin
          if (dx == '0) begin
            // zero-width segment answers with the lower y
            res_hit <= 1'b1;
            res_y   <= y1;
            state   <= S_DONE;
          end else begin
            neg   <= dq[MAG_W-1] ^ dy[MAG_W-1] ^ dx[MAG_W-1];
            state <= S_MULDIV;
          end
        end
        S_MULDIV: begin
          if (md_done) begin
            sum   <= neg ? ({{3{y1[DATA_W-1]}}, y1} - {1'b0, md_offset})
                         : ({{3{y1[DATA_W-1]}}, y1} + {1'b0, md_offset});
            state <= S_SUM;
          end
        end
        S_SUM: begin
          res_hit <= 1'b1;
          if (sum[DATA_W+2:DATA_W-1] == '0 || sum[DATA_W+2:DATA_W-1] == '1) begin
            res_y <= sum[DATA_W-1:0];
          end else if (sum[DATA_W+2]) begin
            res_y <= {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            res_y <= {1'b0, {(DATA_W-1){1'b1}}};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            hit           <= res_hit;
            segment_upper <= res_hit ? ENTRY_W'(lo) : '0;
            echo_x        <= q;
            interp_y      <= res_hit ? res_y : '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // divider never sees a zero-width segment
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    md_start |-> (md_ops.div_d != '0))
    else $error("mul/div started with zero divisor");

  // every probe stays below the last entry
  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_CMP) |-> (rd_addr < n_last))
    else $error("search probe outside table");

  // a miss carries zero index and y
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (segment_upper == '0 && interp_y == '0))
    else $error("miss result with nonzero fields");

  // an accepted query holds off the next item
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_QUERY) |=> in_stall)
    else $error("query accepted without going busy");

endmodule
